>>> sv/mrs_pkg.sv
// Shared constants and types for the mesh radius signature block.
package mrs_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;

    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;
    localparam int unsigned MIX_SHIFT_A = 30;
    localparam int unsigned MIX_SHIFT_B = 27;
    localparam int unsigned MIX_SHIFT_C = 31;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
    } mrs_mul_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        word_t prod;
    } mrs_mul_rsp_t;

endpackage

>>> sv/mrs_if.sv
// Handshake channels: point words in, change result words out.
interface mrs_in_if;
    logic                        valid;
    logic                        ready;
    logic [mrs_pkg::WORD_W-1:0]  radius_bits;
    logic                        point_valid;
    logic                        last_point;

    modport source (output valid, output radius_bits, output point_valid,
                    output last_point, input ready);
    modport sink   (input valid, input radius_bits, input point_valid,
                    input last_point, output ready);
endinterface

interface mrs_out_if;
    logic valid;
    logic ready;
    logic mesh_changed;

    modport source (output valid, output mesh_changed, input ready);
    modport sink   (input valid, input mesh_changed, output ready);
endinterface

>>> sv/mesh_radius_signature_core.sv
// Top level: hash sequencer, frame sums, signature compare and result register.
//
//  channel   direction  handshake     word fields
//  points    sink       valid/ready   radius_bits[63:0], point_valid, last_point
//  result    source     valid/ready   mesh_changed
//
//  A point word holds off the next ready until its hash and square are done: three 64-bit
//  products, each three passes of the one 32x32 multiplier plus issue and collect.
//  A point word marked last then also passes through the close state; a bare end
//  marker goes straight to it; a bare non-last word without a point is dropped.
//  Reset clears the saved signature and the running sums.
//  A closing frame waits while the result register still holds an untaken word.
module mesh_radius_signature_core (
    input  logic  clk,
    input  logic  rst_n,
    mrs_in_if.sink    points,
    mrs_out_if.source result
);
    import mrs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MIX1  = 3'd1;
    localparam logic [2:0] ST_WAIT1 = 3'd2;
    localparam logic [2:0] ST_MIX2  = 3'd3;
    localparam logic [2:0] ST_WAIT2 = 3'd4;
    localparam logic [2:0] ST_SQ    = 3'd5;
    localparam logic [2:0] ST_WAIT3 = 3'd6;
    localparam logic [2:0] ST_CLOSE = 3'd7;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    word_t         x_reg;
    word_t         x_next;
    logic          last_reg;
    logic          last_next;
    logic          sig_valid_reg;
    word_t         saved_count_reg;
    word_t         saved_sum_reg;
    word_t         saved_sq_reg;
    word_t         saved_xor_reg;
    word_t         run_count_reg;
    word_t         run_sum_reg;
    word_t         run_sq_reg;
    word_t         run_xor_reg;
    logic          out_valid_reg;
    logic          out_changed_reg;
    logic          in_fire;
    logic          close_fire;
    logic          changed;
    word_t         hash;
    mrs_mul_req_t  mul_req;
    mrs_mul_rsp_t  mul_rsp;

    mrs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign points.ready = (state_reg == ST_IDLE);
    assign in_fire      = points.valid && points.ready;
    assign close_fire   = (state_reg == ST_CLOSE) && (!out_valid_reg || result.ready);
    assign hash         = mul_rsp.prod ^ (mul_rsp.prod >> MIX_SHIFT_C);

    assign changed = !sig_valid_reg
        || (run_count_reg != saved_count_reg)
        || (run_sum_reg   != saved_sum_reg)
        || (run_sq_reg    != saved_sq_reg)
        || (run_xor_reg   != saved_xor_reg);

    always_comb
    begin
        mul_req.start = 1'b0;
        mul_req.a     = x_reg;
        mul_req.b     = x_reg;
        state_next    = state_reg;
        x_next        = x_reg;
        last_next     = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    x_next    = points.radius_bits + GOLDEN_STEP;
                    last_next = points.last_point;
                    if (points.point_valid)
                        state_next = ST_MIX1;
                    else if (points.last_point)
                        state_next = ST_CLOSE;
                end
            end
            ST_MIX1:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = x_reg ^ (x_reg >> MIX_SHIFT_A);
                mul_req.b     = MIX_MUL_A;
                state_next    = ST_WAIT1;
            end
            ST_WAIT1:
            begin
                if (mul_rsp.done)
                begin
                    x_next     = mul_rsp.prod;
                    state_next = ST_MIX2;
                end
            end
            ST_MIX2:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = x_reg ^ (x_reg >> MIX_SHIFT_B);
                mul_req.b     = MIX_MUL_B;
                state_next    = ST_WAIT2;
            end
            ST_WAIT2:
            begin
                if (mul_rsp.done)
                begin
                    x_next     = hash;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                mul_req.start = 1'b1;
                state_next    = ST_WAIT3;
            end
            ST_WAIT3:
            begin
                if (mul_rsp.done)
                    state_next = last_reg ? ST_CLOSE : ST_IDLE;
            end
            ST_CLOSE:
            begin
                if (close_fire)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sig_valid_reg   <= 1'b0;
            saved_count_reg <= '0;
            saved_sum_reg   <= '0;
            saved_sq_reg    <= '0;
            saved_xor_reg   <= '0;
            run_count_reg   <= '0;
            run_sum_reg     <= '0;
            run_sq_reg      <= '0;
            run_xor_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (close_fire)
                out_valid_reg <= 1'b1;
            else if (result.valid && result.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_SQ)
            begin
                run_count_reg <= run_count_reg + word_t'(1);
                run_sum_reg   <= run_sum_reg + x_reg;
                run_xor_reg   <= run_xor_reg ^ x_reg;
            end
            if (state_reg == ST_WAIT3 && mul_rsp.done)
                run_sq_reg <= run_sq_reg + mul_rsp.prod;
            if (close_fire)
            begin
                sig_valid_reg   <= 1'b1;
                saved_count_reg <= run_count_reg;
                saved_sum_reg   <= run_sum_reg;
                saved_sq_reg    <= run_sq_reg;
                saved_xor_reg   <= run_xor_reg;
                run_count_reg   <= '0;
                run_sum_reg     <= '0;
                run_sq_reg      <= '0;
                run_xor_reg     <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        last_reg <= last_next;
        if (close_fire)
            out_changed_reg <= changed;
    end

    assign result.valid        = out_valid_reg;
    assign result.mesh_changed = out_changed_reg;

    a_close_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        close_fire |=> (out_valid_reg && sig_valid_reg && run_count_reg == '0))
        else $error("frame close did not load result and clear sums");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_WAIT1 || state_reg == ST_WAIT2
                          || state_reg == ST_WAIT3))
        else $error("multiplier finished outside a wait state");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.busy |-> !points.ready)
        else $error("ready raised while multiplier busy");

    a_close_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE && out_valid_reg && !result.ready)
        |=> (state_reg == ST_CLOSE))
        else $error("frame closed over an untaken result");

endmodule

>>> sv/mrs_mul.sv
// Iterative 64x64 low-half multiplier built on one 32x32 multiplier.
module mrs_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mrs_pkg::mrs_mul_req_t req,
    output mrs_pkg::mrs_mul_rsp_t rsp
);
    import mrs_pkg::*;

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;

    word_t              a_reg;
    word_t              b_reg;
    word_t              acc_reg;
    word_t              acc_next;
    logic               busy_reg;
    logic               done_reg;
    logic [1:0]         step_reg;
    logic [HALF_W-1:0]  mul_x;
    logic [HALF_W-1:0]  mul_y;
    word_t              part;

    always_comb
    begin
        case (step_reg)
            STEP_LL:
            begin
                mul_x = a_reg[HALF_W-1:0];
                mul_y = b_reg[HALF_W-1:0];
            end
            STEP_LH:
            begin
                mul_x = a_reg[HALF_W-1:0];
                mul_y = b_reg[WORD_W-1:HALF_W];
            end
            default:
            begin
                mul_x = a_reg[WORD_W-1:HALF_W];
                mul_y = b_reg[HALF_W-1:0];
            end
        endcase
        part = word_t'(mul_x) * word_t'(mul_y);
        if (step_reg == STEP_LL)
            acc_next = part;
        else
            acc_next = {acc_reg[WORD_W-1:HALF_W] + part[HALF_W-1:0],
                        acc_reg[HALF_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_LL;
        end
        else
        begin
            if (req.start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                step_reg <= STEP_LL;
            end
            else if (busy_reg && step_reg == STEP_HL)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
                step_reg <= STEP_LL;
            end
            else
            begin
                done_reg <= 1'b0;
                if (busy_reg)
                    step_reg <= step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (busy_reg)
            acc_reg <= acc_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier restarted while busy");

    a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && step_reg == STEP_HL) |=> (done_reg && !busy_reg))
        else $error("multiplier did not finish after its last step");

endmodule

>>> bench/testbench.sv
// Testbench for the mesh radius signature core: point frames in, change flags checked.
`timescale 1ns / 100ps

module testbench;

    import mrs_pkg::*;

    class mesh_signature_board;
        bit          have_signature;
        word_t       saved_count      = '0;
        word_t       saved_hash_sum   = '0;
        word_t       saved_square_sum = '0;
        word_t       saved_hash_xor   = '0;
        word_t       frame_count      = '0;
        word_t       frame_hash_sum   = '0;
        word_t       frame_square_sum = '0;
        word_t       frame_hash_xor   = '0;
        bit          pending_changes[$];
        int unsigned errors;

        function word_t splitmix_finalize(word_t v);
            word_t x;
            x = v + GOLDEN_STEP;
            x = (x ^ (x >> MIX_SHIFT_A)) * MIX_MUL_A;
            x = (x ^ (x >> MIX_SHIFT_B)) * MIX_MUL_B;
            return x ^ (x >> MIX_SHIFT_C);
        endfunction

        function void note_word(word_t bits, bit has_point, bit closes);
            word_t h;
            bit    changed;
            if (has_point)
            begin
                h = splitmix_finalize(bits);
                frame_count      = frame_count + 1;
                frame_hash_sum   = frame_hash_sum + h;
                frame_square_sum = frame_square_sum + h * h;
                frame_hash_xor   = frame_hash_xor ^ h;
            end
            if (closes)
            begin
                changed = !have_signature
                    || frame_count != saved_count
                    || frame_hash_sum != saved_hash_sum
                    || frame_square_sum != saved_square_sum
                    || frame_hash_xor != saved_hash_xor;
                have_signature   = 1'b1;
                saved_count      = frame_count;
                saved_hash_sum   = frame_hash_sum;
                saved_square_sum = frame_square_sum;
                saved_hash_xor   = frame_hash_xor;
                frame_count      = '0;
                frame_hash_sum   = '0;
                frame_square_sum = '0;
                frame_hash_xor   = '0;
                pending_changes  = {pending_changes, changed};
            end
        endfunction

        function void check_result(logic changed);
            bit want;
            if (pending_changes.size() == 0)
            begin
                $error("mesh_changed: expected no word, actual %0b", changed);
                errors++;
            end
            else
            begin
                want = pending_changes.pop_front();
                if (changed !== want)
                begin
                    $error("mesh_changed: expected %0b, actual %0b", want, changed);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mrs_in_if  points_ch ();
    mrs_out_if result_ch ();

    mesh_radius_signature_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points_ch),
        .result (result_ch)
    );

    mesh_signature_board board = new;

    int unsigned words_sent;
    int unsigned burst_left;
    word_t       frame_q[$];
    word_t       prev_q[$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int unsigned stretch;
        int unsigned duty;
        result_ch.ready <= 1'b0;
        forever
        begin
            stretch = $urandom_range(10, 80);
            case ($urandom_range(0, 3))
                0:       duty = 100;
                1:       duty = 50;
                2:       duty = 10;
                default: duty = 85;
            endcase
            repeat (stretch)
            begin
                @(posedge clk);
                if (result_ch.valid && result_ch.ready)
                    board.check_result(result_ch.mesh_changed);
                result_ch.ready <= ($urandom_range(0, 99) < duty);
            end
        end
    end

    function automatic word_t pick_radius();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return {1'b0, 11'($urandom_range(1000, 1100)), 20'($urandom), $urandom};
            3:       return word_t'(1) << $urandom_range(0, WORD_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_word(input word_t bits, input bit has_point, input bit closes);
        points_ch.valid       <= 1'b1;
        points_ch.radius_bits <= bits;
        points_ch.point_valid <= has_point;
        points_ch.last_point  <= closes;
        do
            @(posedge clk);
        while (!points_ch.ready);
        board.note_word(bits, has_point, closes);
        words_sent++;
        if (burst_left == 0)
        begin
            points_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
        else
            burst_left--;
    endtask

    task automatic send_frame(input bit bare_end, input int unsigned noise_pct);
        int unsigned n;
        n = frame_q.size();
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                push_word({$urandom, $urandom}, 1'b0, 1'b0);
            push_word(frame_q[i], 1'b1, !bare_end && i == n - 1);
        end
        if (bare_end || n == 0)
            push_word({$urandom, $urandom}, 1'b0, 1'b1);
        prev_q = frame_q;
    endtask

    task automatic shuffle_frame();
        word_t       tmp;
        int unsigned j;
        for (int i = frame_q.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = frame_q[i];
            frame_q[i] = frame_q[j];
            frame_q[j] = tmp;
        end
    endtask

    initial
    begin
        int unsigned n;
        int unsigned k;
        rst_n                 <= 1'b0;
        points_ch.valid       <= 1'b0;
        points_ch.radius_bits <= '0;
        points_ch.point_valid <= 1'b0;
        points_ch.last_point  <= 1'b0;
        words_sent = 0;
        burst_left = 4;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        frame_q = {};
        send_frame(1'b1, 0);
        send_frame(1'b1, 0);
        frame_q = {64'h0};
        send_frame(1'b0, 0);
        send_frame(1'b1, 0);
        frame_q = {64'hffff_ffff_ffff_ffff};
        send_frame(1'b0, 0);
        frame_q = {64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000, 64'h1};
        send_frame(1'b0, 0);
        frame_q = {64'h1, 64'h7ff0_0000_0000_0000, 64'h8000_0000_0000_0000};
        send_frame(1'b1, 0);
        push_word(64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);
        push_word(64'h0, 1'b0, 1'b0);
        frame_q = {};
        send_frame(1'b1, 0);
        frame_q = {-GOLDEN_STEP};
        send_frame(1'b0, 0);
        frame_q = {64'h0, 64'h0};
        send_frame(1'b0, 0);
        frame_q = {64'h3ff0_0000_0000_0000, 64'hfff8_0000_0000_0000};
        send_frame(1'b0, 50);

        while (words_sent < 900)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    frame_q = prev_q;
                    shuffle_frame();
                end
                2:
                begin
                    frame_q = prev_q;
                    if (frame_q.size() != 0)
                    begin
                        k = $urandom_range(0, frame_q.size() - 1);
                        frame_q[k][$urandom_range(0, WORD_W - 1)] ^= 1'b1;
                    end
                end
                3:
                    frame_q = {};
                default:
                begin
                    frame_q = {};
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                                    : $urandom_range(1, 6);
                    repeat (n) frame_q = {frame_q, pick_radius()};
                end
            endcase
            send_frame($urandom_range(0, 2) == 0, 12);
        end
        if (points_ch.valid)
            points_ch.valid <= 1'b0;

        while (board.pending_changes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (board.errors == 0 && board.pending_changes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
